>>> src/wpf_pkg.sv
// Shared types and constants for the word packet framer with CRC-16.
// No dependencies; used by the interfaces and all framer modules.
`default_nettype none

package wpf_pkg;

  localparam int unsigned BUFFER_WORDS_DEF = 512;
  localparam logic [31:0] SYNC_RESET = 32'hAA55AA55;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_START    = 3'd0;
  localparam action_t ACT_PAYLOAD  = 3'd1;
  localparam action_t ACT_ADD      = 3'd2;
  localparam action_t ACT_COMPLETE = 3'd3;
  localparam action_t ACT_READ     = 3'd4;
  localparam action_t ACT_CANCEL   = 3'd5;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_IGNORED = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

endpackage

`default_nettype wire

>>> src/wpf_in_if.sv
// Command channel of the framer: valid/ready plus one command word.
// Depends on wpf_pkg.
`default_nettype none

interface wpf_in_if;
  import wpf_pkg::*;

  logic        valid;
  logic        ready;
  action_t     action;
  logic [15:0] payload_type;
  logic [31:0] data_word;

  modport source (output valid, action, payload_type, data_word, input ready);
  modport sink   (input valid, action, payload_type, data_word, output ready);
endinterface

`default_nettype wire

>>> src/wpf_out_if.sv
// Result channel of the framer: valid/ready plus one result word.
// Depends on wpf_pkg.
`default_nettype none

interface wpf_out_if;
  import wpf_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] out_word;
  logic        out_valid;
  logic        last;
  logic        started;
  logic        complete;

  modport source (output valid, status, out_word, out_valid, last, started, complete,
                  input ready);
  modport sink   (input valid, status, out_word, out_valid, last, started, complete,
                  output ready);
endinterface

`default_nettype wire

>>> src/word_packet_framer_crc16.sv
// Word packet framer: builds a packet in a word memory, seals it with CRC-16, reads it out.
// Uses wpf_pkg, wpf_in_if, wpf_out_if, wpf_store and wpf_crc.
//
// in_ch carries commands (start packet, start payload, add word, complete, read next,
// cancel); out_ch returns exactly one result word per command, in order. cfg_we/cfg_wdata
// write the sync word, taken into word 0 at each start packet.
// Start packet, start payload, cancel, refused and ignored commands, and add word with no
// payload open are answered straight from the idle state. Add word into an open payload
// writes the data word, then rewrites the payload header on the single memory write port.
// Read next waits for the registered memory read. Complete reads each stored word from
// memory and feeds it through the CRC unit in four byte steps, low byte first.
// in_ch.ready is high only while the sequencer is idle and the result register is free or
// being drained. A result waits in the output register while out_ch.ready is low; the
// sequencer holds a finished multi-cycle result until the register frees.
// Reset (rst, synchronous) clears state, flags and write/read/header indexes and restores
// the sync word to 0xAA55AA55; memory contents are not cleared and need no clearing pass.
`default_nettype none

module word_packet_framer_crc16 #(
  parameter int unsigned BUFFER_WORDS = wpf_pkg::BUFFER_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  wpf_in_if.sink      in_ch,
  wpf_out_if.source   out_ch
);
  import wpf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BUFFER_WORDS);
  localparam int unsigned IDX_W  = $clog2(BUFFER_WORDS + 1);
  localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(BUFFER_WORDS);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_HDR      = 3'd1;
  localparam logic [2:0] S_RD       = 3'd2;
  localparam logic [2:0] S_CRC_RD   = 3'd3;
  localparam logic [2:0] S_CRC_BYTE = 3'd4;
  localparam logic [2:0] S_CFIN     = 3'd5;

  logic [2:0]        state, state_next;
  logic [31:0]       sync_word;
  logic [IDX_W-1:0]  write_index, write_index_next;
  logic [IDX_W-1:0]  read_index, read_index_next;
  logic [IDX_W-1:0]  crc_index, crc_index_next;
  logic [ADDR_W-1:0] ph_index, ph_index_next;
  logic [15:0]       ph_type, ph_type_next;
  logic [7:0]        ph_count, ph_count_next;
  logic              payload_open, payload_open_next;
  logic              started, started_next;
  logic              complete, complete_next;
  logic [31:0]       word0, word0_next;
  logic [15:0]       crc_hi, crc_hi_next;
  logic [1:0]        byte_cnt, byte_cnt_next;
  logic [15:0]       count16;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;

  logic              crc_init, crc_step;
  logic [7:0]        crc_byte;
  logic [15:0]       crc;

  logic              o_valid, slot_free, accept, emit;
  status_t           res_status;
  logic [31:0]       res_word;
  logic              res_oval, res_last;

  assign slot_free    = !o_valid || out_ch.ready;
  assign in_ch.ready  = (state == S_IDLE) && slot_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign count16      = 16'(write_index) - 16'd2;
  assign crc_byte     = mem_rdata[{byte_cnt, 3'b000} +: 8];

  wpf_store #(.DEPTH(BUFFER_WORDS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wpf_crc u_crc (
    .clk       (clk),
    .init      (crc_init),
    .step      (crc_step),
    .data_byte (crc_byte),
    .crc       (crc)
  );

  always_comb begin
    state_next        = state;
    write_index_next  = write_index;
    read_index_next   = read_index;
    crc_index_next    = crc_index;
    ph_index_next     = ph_index;
    ph_type_next      = ph_type;
    ph_count_next     = ph_count;
    payload_open_next = payload_open;
    started_next      = started;
    complete_next     = complete;
    word0_next        = word0;
    crc_hi_next       = crc_hi;
    byte_cnt_next     = byte_cnt;
    mem_we            = 1'b0;
    mem_waddr         = write_index[ADDR_W-1:0];
    mem_wdata         = in_ch.data_word;
    mem_re            = 1'b0;
    mem_raddr         = read_index[ADDR_W-1:0];
    crc_init          = 1'b0;
    crc_step          = 1'b0;
    emit              = 1'b0;
    res_status        = ST_IGNORED;
    res_word          = '0;
    res_oval          = 1'b0;
    res_last          = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            ACT_START: begin
              complete_next     = 1'b0;
              started_next      = 1'b1;
              payload_open_next = 1'b0;
              read_index_next   = '0;
              word0_next        = sync_word;
              crc_hi_next       = CRC_INIT;
              write_index_next  = IDX_FIRST;
              res_status        = ST_DONE;
              emit              = 1'b1;
            end
            ACT_PAYLOAD, ACT_ADD: begin
              if (!started) begin
                res_status = ST_IGNORED;
                emit       = 1'b1;
              end else if (write_index == IDX_FULL) begin
                res_status = ST_FULL;
                emit       = 1'b1;
              end else begin
                mem_we           = 1'b1;
                write_index_next = write_index + IDX_ONE;
                res_status       = ST_DONE;
                if (in_ch.action == ACT_PAYLOAD) begin
                  mem_wdata         = {in_ch.payload_type, 16'h0000};
                  ph_index_next     = write_index[ADDR_W-1:0];
                  ph_type_next      = in_ch.payload_type;
                  ph_count_next     = '0;
                  payload_open_next = 1'b1;
                  emit              = 1'b1;
                end else if (payload_open) begin
                  ph_count_next = ph_count + 8'd1;
                  state_next    = S_HDR;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            ACT_COMPLETE: begin
              if (started && !complete) begin
                crc_init       = 1'b1;
                crc_index_next = IDX_FIRST;
                state_next     = S_CRC_RD;
              end else begin
                res_status = ST_IGNORED;
                emit       = 1'b1;
              end
            end
            ACT_READ: begin
              if (complete && (read_index < write_index)) begin
                mem_re     = 1'b1;
                state_next = S_RD;
              end else begin
                res_status = ST_EMPTY;
                emit       = 1'b1;
              end
            end
            ACT_CANCEL: begin
              started_next      = 1'b0;
              payload_open_next = 1'b0;
              res_status        = ST_DONE;
              emit              = 1'b1;
            end
            default: begin
              res_status = ST_IGNORED;
              emit       = 1'b1;
            end
          endcase
        end
      end
      S_HDR: begin
        // rewrite the open payload header with its bumped count
        mem_we     = 1'b1;
        mem_waddr  = ph_index;
        mem_wdata  = {ph_type, 8'h00, ph_count};
        res_status = ST_DONE;
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        res_status = ST_DONE;
        res_oval   = 1'b1;
        res_last   = (read_index + IDX_ONE) == write_index;
        if (read_index == '0) begin
          res_word = word0;
        end else if (read_index == IDX_ONE) begin
          res_word = {crc_hi, count16};
        end else begin
          res_word = mem_rdata;
        end
        if (slot_free) begin
          emit            = 1'b1;
          read_index_next = read_index + IDX_ONE;
          state_next      = S_IDLE;
        end
      end
      S_CRC_RD: begin
        if (crc_index == write_index) begin
          state_next = S_CFIN;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = crc_index[ADDR_W-1:0];
          byte_cnt_next = '0;
          state_next    = S_CRC_BYTE;
        end
      end
      S_CRC_BYTE: begin
        crc_step      = 1'b1;
        byte_cnt_next = byte_cnt + 2'd1;
        if (byte_cnt == 2'd3) begin
          crc_index_next = crc_index + IDX_ONE;
          state_next     = S_CRC_RD;
        end
      end
      S_CFIN: begin
        res_status = ST_DONE;
        if (slot_free) begin
          crc_hi_next       = crc;
          complete_next     = 1'b1;
          started_next      = 1'b0;
          payload_open_next = 1'b0;
          read_index_next   = '0;
          emit              = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sync_word    <= SYNC_RESET;
      write_index  <= '0;
      read_index   <= '0;
      ph_index     <= '0;
      payload_open <= 1'b0;
      started      <= 1'b0;
      complete     <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      write_index  <= write_index_next;
      read_index   <= read_index_next;
      ph_index     <= ph_index_next;
      payload_open <= payload_open_next;
      started      <= started_next;
      complete     <= complete_next;
      if (cfg_we) begin
        sync_word <= cfg_wdata;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_index <= crc_index_next;
    ph_type   <= ph_type_next;
    ph_count  <= ph_count_next;
    word0     <= word0_next;
    crc_hi    <= crc_hi_next;
    byte_cnt  <= byte_cnt_next;
    if (emit) begin
      out_ch.status    <= res_status;
      out_ch.out_word  <= res_word;
      out_ch.out_valid <= res_oval;
      out_ch.last      <= res_last;
      out_ch.started   <= started_next;
      out_ch.complete  <= complete_next;
    end
  end

  assign out_ch.valid = o_valid;

`ifndef SYNTHESIS
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (write_index <= IDX_FULL) && (read_index <= write_index || !complete))
    else $error("framer index out of range");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(started && complete))
    else $error("started and complete both set");

  a_word_done: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.out_valid |-> out_ch.status == ST_DONE)
    else $error("read word with non-done status");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last |-> out_ch.out_valid && out_ch.complete)
    else $error("last flag without a read word");
`endif

endmodule

`default_nettype wire

>>> src/wpf_store.sv
// Packet word memory: one write port, one read port with registered data.
// No package dependency beyond the default depth.
`default_nettype none

module wpf_store #(
  parameter int unsigned DEPTH = wpf_pkg::BUFFER_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/wpf_crc.sv
// CRC-16 (poly 0x1021, MSB first) unit, one byte per step.
// Depends on wpf_pkg for the init value.
`default_nettype none

module wpf_crc (
  input  logic        clk,
  input  logic        init,
  input  logic        step,
  input  logic [7:0]  data_byte,
  output logic [15:0] crc
);
  import wpf_pkg::*;

  localparam logic [15:0] POLY = 16'h1021;

  logic [15:0] crc_next;

  always_comb begin
    crc_next = crc ^ {data_byte, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc_next[15]) begin
        crc_next = {crc_next[14:0], 1'b0} ^ POLY;
      end else begin
        crc_next = {crc_next[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      crc <= CRC_INIT;
    end else if (step) begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/word_packet_framer_crc16_tb.sv
`timescale 1ns / 1ps
// Testbench for word_packet_framer_crc16: directed and random command words checked
// word by word against a local packet/CRC-16 predictor, with random idling on both sides.
// Depends on wpf_pkg, wpf_in_if, wpf_out_if and the framer RTL.

module word_packet_framer_crc16_tb;
  import wpf_pkg::*;

  localparam int unsigned BUF_WORDS = BUFFER_WORDS_DEF;
  localparam action_t ACT_RSVD6 = 3'd6;
  localparam action_t ACT_RSVD7 = 3'd7;
  localparam longint LIMIT_NS = 10_000_000;

  typedef struct packed {
    status_t     status;
    logic [31:0] word;
    logic        wvalid;
    logic        last;
    logic        started;
    logic        complete;
  } frame_res_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  wpf_in_if  in_ch ();
  wpf_out_if out_ch ();

  word_packet_framer_crc16 #(
    .BUFFER_WORDS(BUF_WORDS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predicted framer state
  logic [31:0] pk_sync;
  logic [31:0] pk_mem [BUF_WORDS];
  logic [9:0]  pk_wr;
  logic [9:0]  pk_rd;
  logic [8:0]  pk_hdr;
  logic        pk_open;
  logic        pk_started;
  logic        pk_sealed;

  frame_res_t expected_q[$];

  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_sealed = 0;
  int unsigned n_words_out = 0;
  int unsigned n_full = 0;
  int unsigned n_sync_writes = 0;
  int unsigned idle_pct = 30;
  int unsigned hold_req = 0;
  int unsigned hold_cnt = 0;
  int unsigned stall_cnt = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("FAIL word_packet_framer_crc16");
    $finish;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(60, 20);
    return $urandom_range(4, 1);
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic frame_res_t frame_predict(action_t act, logic [15:0] ptype,
                                               logic [31:0] dw);
    frame_res_t  r;
    logic [15:0] crc;
    logic [31:0] w;
    r = '0;
    r.status = ST_IGNORED;
    case (act)
      ACT_START: begin
        pk_sealed  = 1'b0;
        pk_started = 1'b1;
        pk_open    = 1'b0;
        pk_rd      = '0;
        pk_mem[0]  = pk_sync;
        pk_mem[1]  = 32'hFFFF0000;
        pk_wr      = 10'd2;
        r.status   = ST_DONE;
      end
      ACT_PAYLOAD, ACT_ADD: begin
        if (!pk_started) begin
          r.status = ST_IGNORED;
        end else if (pk_wr >= BUF_WORDS) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          if (act == ACT_PAYLOAD) begin
            pk_hdr = pk_wr[8:0];
            pk_open = 1'b1;
            pk_mem[pk_wr[8:0]] = {ptype, 16'h0000};
          end else begin
            pk_mem[pk_wr[8:0]] = dw;
          end
          pk_wr = pk_wr + 10'd1;
          pk_mem[1][15:0] = 16'(pk_wr) - 16'd2;
          if (act == ACT_ADD && pk_open) pk_mem[pk_hdr][7:0] = pk_mem[pk_hdr][7:0] + 8'd1;
          r.status = ST_DONE;
        end
      end
      ACT_COMPLETE: begin
        if (pk_started && !pk_sealed) begin
          crc = 16'hFFFF;
          for (int i = 2; i < pk_wr; i++) begin
            w = pk_mem[9'(i)];
            crc = crc16_byte(crc, w[7:0]);
            crc = crc16_byte(crc, w[15:8]);
            crc = crc16_byte(crc, w[23:16]);
            crc = crc16_byte(crc, w[31:24]);
          end
          pk_mem[1][31:16] = crc;
          pk_sealed  = 1'b1;
          pk_started = 1'b0;
          pk_open    = 1'b0;
          pk_rd      = '0;
          r.status   = ST_DONE;
          n_sealed++;
        end
      end
      ACT_READ: begin
        if (pk_sealed && pk_rd < pk_wr) begin
          r.word   = pk_mem[pk_rd[8:0]];
          r.wvalid = 1'b1;
          r.last   = (pk_rd + 1 == pk_wr);
          pk_rd    = pk_rd + 10'd1;
          r.status = ST_DONE;
          n_words_out++;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_CANCEL: begin
        pk_started = 1'b0;
        pk_open    = 1'b0;
        r.status   = ST_DONE;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.started  = pk_started;
    r.complete = pk_sealed;
    return r;
  endfunction

  task automatic send_cmd(action_t act, logic [15:0] ptype, logic [31:0] dw);
    int unsigned gap;
    frame_res_t  r;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.payload_type <= ptype;
    in_ch.data_word    <= dw;
    do @(posedge clk); while (!in_ch.ready);
    r = frame_predict(act, ptype, dw);
    expected_q.push_back(r);
    n_sent++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_sync(logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pk_sync = v;
    n_sync_writes++;
  endtask

  task automatic read_out(int unsigned n);
    repeat (n) send_cmd(ACT_READ, 16'($urandom), $urandom);
  endtask

  task automatic send_noise();
    send_cmd(action_t'($urandom_range(7)), 16'($urandom), $urandom);
  endtask

  // packet with random content and occasional noise commands, ended by complete or cancel
  task automatic send_packet(int unsigned max_add);
    int unsigned sel;
    send_cmd(ACT_START, 16'($urandom), $urandom);
    if ($urandom_range(3) == 0) repeat ($urandom_range(3)) send_cmd(ACT_ADD, 16'($urandom), $urandom);
    repeat ($urandom_range(3)) begin
      send_cmd(ACT_PAYLOAD, 16'($urandom), $urandom);
      repeat ($urandom_range(max_add)) send_cmd(ACT_ADD, 16'($urandom), $urandom);
      if ($urandom_range(15) == 0) send_noise();
    end
    sel = $urandom_range(9);
    if (sel == 0) begin
      send_cmd(ACT_CANCEL, 16'($urandom), $urandom);
      send_cmd(ACT_COMPLETE, 16'($urandom), $urandom);
      read_out(1);
    end else begin
      send_cmd(ACT_COMPLETE, 16'($urandom), $urandom);
      if (sel == 1) send_cmd(ACT_CANCEL, 16'($urandom), $urandom);
      if (sel == 2) read_out($urandom_range(pk_wr));
      else read_out(pk_wr + 1);
    end
  endtask

  task automatic test_directed();
    read_out(1);
    send_cmd(ACT_PAYLOAD, 16'hFFFF, 32'h0);
    send_cmd(ACT_ADD, 16'h0, 32'hFFFFFFFF);
    send_cmd(ACT_COMPLETE, 16'h0, 32'h0);
    send_cmd(ACT_RSVD6, 16'hFFFF, 32'hFFFFFFFF);
    send_cmd(ACT_RSVD7, 16'h0, 32'h0);
    send_cmd(ACT_CANCEL, 16'h0, 32'h0);
    // header-only packet with the reset sync word
    send_cmd(ACT_START, 16'h0, 32'h0);
    send_cmd(ACT_COMPLETE, 16'h0, 32'h0);
    send_cmd(ACT_COMPLETE, 16'h0, 32'h0);
    read_out(3);
    // words before any payload header, then two payloads
    send_cmd(ACT_START, 16'hFFFF, 32'hFFFFFFFF);
    send_cmd(ACT_ADD, 16'h0, 32'h00000000);
    send_cmd(ACT_ADD, 16'h0, 32'hFFFFFFFF);
    send_cmd(ACT_PAYLOAD, 16'hFFFF, 32'h0);
    send_cmd(ACT_ADD, 16'h0, 32'h12345678);
    send_cmd(ACT_PAYLOAD, 16'h0000, 32'hFFFFFFFF);
    send_cmd(ACT_ADD, 16'hA5A5, 32'h80000001);
    send_cmd(ACT_CANCEL, 16'h0, 32'h0);
    send_cmd(ACT_ADD, 16'h0, 32'h1);
    send_cmd(ACT_COMPLETE, 16'h0, 32'h0);
    read_out(1);
    wait_drain();
  endtask

  task automatic test_sync_extremes();
    logic [31:0] vals [3];
    vals[0] = 32'h00000000;
    vals[1] = 32'hFFFFFFFF;
    vals[2] = $urandom;
    for (int i = 0; i < 3; i++) begin
      set_sync(vals[i]);
      send_cmd(ACT_START, 16'($urandom), $urandom);
      send_cmd(ACT_PAYLOAD, 16'($urandom), $urandom);
      repeat (3) send_cmd(ACT_ADD, 16'($urandom), $urandom);
      send_cmd(ACT_COMPLETE, 16'($urandom), $urandom);
      read_out(pk_wr + 1);
      wait_drain();
    end
  endtask

  // fills the store, wraps the payload count, then checks refusals and the sealed headers
  task automatic test_full_buffer();
    idle_pct = 10;
    set_sync($urandom);
    send_cmd(ACT_START, 16'($urandom), $urandom);
    send_cmd(ACT_PAYLOAD, 16'($urandom), $urandom);
    while (pk_wr < BUF_WORDS) send_cmd(ACT_ADD, 16'($urandom), $urandom);
    send_cmd(ACT_ADD, 16'($urandom), $urandom);
    send_cmd(ACT_PAYLOAD, 16'($urandom), $urandom);
    send_cmd(ACT_ADD, 16'($urandom), $urandom);
    send_cmd(ACT_COMPLETE, 16'($urandom), $urandom);
    read_out(4);
    wait_drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    hold_req = 400;
    send_packet(6);
    send_packet(6);
    read_out(10);
    wait_drain();
  endtask

  task automatic test_random();
    int unsigned target;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drain();
      set_sync($urandom);
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 20;
        2: idle_pct = 50;
        default: idle_pct = 80;
      endcase
      target = n_sent + 40;
      while (n_sent < target) begin
        if ($urandom_range(99) < 80) send_packet(phase == 3 ? 40 : 8);
        else send_noise();
      end
    end
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        stall_cnt = pick_gap();
        out_ch.ready <= (stall_cnt == 0);
      end
    end
  end

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual status %0d out_word %h",
                 $time, out_ch.status, out_ch.out_word);
      end else begin
        e = expected_q.pop_front();
        check_field("status", 32'(e.status), 32'(out_ch.status));
        check_field("out_word", e.word, out_ch.out_word);
        check_field("out_valid", 32'(e.wvalid), 32'(out_ch.out_valid));
        check_field("last", 32'(e.last), 32'(out_ch.last));
        check_field("started", 32'(e.started), 32'(out_ch.started));
        check_field("complete", 32'(e.complete), 32'(out_ch.complete));
        n_checked++;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_CANCEL;
    in_ch.payload_type = '0;
    in_ch.data_word    = '0;
    pk_sync    = SYNC_RESET;
    pk_wr      = '0;
    pk_rd      = '0;
    pk_hdr     = '0;
    pk_open    = 1'b0;
    pk_started = 1'b0;
    pk_sealed  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_sync_extremes();
    test_full_buffer();
    test_backpressure();
    test_random();

    wait_drain();
    repeat (20) @(posedge clk);
    $display("Checked %0d words for %0d accepted commands under %0d sync word settings.",
             n_checked, n_sent, n_sync_writes + 1);
    $display("Sealed %0d packets, read out %0d words, saw %0d full-store refusals.",
             n_sealed, n_words_out, n_full);
    if (errors == 0) begin
      $display("PASS word_packet_framer_crc16");
    end else begin
      $display("FAIL word_packet_framer_crc16");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/wpf_pkg.sv
src/wpf_in_if.sv
src/wpf_out_if.sv
src/wpf_store.sv
src/wpf_crc.sv
src/word_packet_framer_crc16.sv
tb/word_packet_framer_crc16_tb.sv
